### rtl/core/bsp_pkg.sv
// shared constants, types and state codes for the bfs shortest path unit
package bsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = 7;
  localparam int NW = 2 * VW;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic signed [CW-1:0] HOP_UNREACHABLE = -7'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RA, S_LD_WA, S_LD_RB, S_LD_WB,
    S_Q_INIT, S_Q_POP, S_Q_V, S_Q_ROW, S_Q_SCAN,
    S_W_ISSUE, S_W_DATA, S_E_RD, S_E_OUT, S_UNR
  } state_t;

  typedef struct packed {
    logic                    we;
    logic [VW-1:0]           waddr;
    logic [MAX_VERTICES-1:0] wdata;
    logic [VW-1:0]           raddr;
  } adj_req_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    logic [NW-1:0] wdata;
    logic [VW-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [VW-1:0] raddr;
  } queue_req_t;

endpackage

### rtl/core/bfs_shortest_path_unit.sv
// bfs shortest path unit: adjacency, node and queue memories around the sequencer
// clear, ignored commands and loads with edge bit 0 end at acceptance; a load with edge bit 1 reads
// and rewrites row a, then row b; a query searches (init, then per dequeued vertex pop, row read and
// a scan marking each new vertex), walks the path back, outputs each result; registered memory reads
// set the pace; out-of-range queries go straight to S_UNR; the receiver cannot stall, so nothing waits on it
// synchronous active-low reset clears the graph (row valid bits) and sets vertex_count to 64
module bfs_shortest_path_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [bsp_pkg::VW-1:0]        in_first_vertex,
  input  logic [bsp_pkg::VW-1:0]        in_second_vertex,
  input  logic                          in_edge_bit,
  input  logic                          cfg_we,
  input  logic [bsp_pkg::CW-1:0]        cfg_wdata,
  output logic                          out_strobe,
  output logic signed [bsp_pkg::CW-1:0] out_hop_distance,
  output logic [bsp_pkg::VW-1:0]        out_path_vertex,
  output logic                          out_last
);
  import bsp_pkg::*;

  logic [CW-1:0]           vcount_r;
  adj_req_t                adj_req;
  node_req_t               node_req;
  queue_req_t              q_req;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [NW-1:0]           node_rdata;
  logic [VW-1:0]           q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CW'(MAX_VERTICES);
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  bsp_ram #(.W(MAX_VERTICES), .D(MAX_VERTICES)) u_adj (
    .clk(clk), .we(adj_req.we), .waddr(adj_req.waddr), .wdata(adj_req.wdata),
    .raddr(adj_req.raddr), .rdata(adj_rdata)
  );

  bsp_ram #(.W(NW), .D(MAX_VERTICES)) u_node (
    .clk(clk), .we(node_req.we), .waddr(node_req.waddr), .wdata(node_req.wdata),
    .raddr(node_req.raddr), .rdata(node_rdata)
  );

  bsp_ram #(.W(VW), .D(MAX_VERTICES)) u_queue (
    .clk(clk), .we(q_req.we), .waddr(q_req.waddr), .wdata(q_req.wdata),
    .raddr(q_req.raddr), .rdata(q_rdata)
  );

  bsp_engine u_engine (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_first_vertex(in_first_vertex),
    .in_second_vertex(in_second_vertex), .in_edge_bit(in_edge_bit),
    .vertex_count(vcount_r),
    .adj_req(adj_req), .adj_rdata(adj_rdata),
    .node_req(node_req), .node_rdata(node_rdata),
    .q_req(q_req), .q_rdata(q_rdata),
    .out_strobe(out_strobe), .out_hop_distance(out_hop_distance),
    .out_path_vertex(out_path_vertex), .out_last(out_last)
  );
endmodule

### rtl/core/bsp_ram.sv
// generic single write port ram with registered read
module bsp_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/bsp_engine.sv
// sequencer for edge loads, breadth-first search, path walk-back and result output
module bsp_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_cmd,
  input  logic [bsp_pkg::VW-1:0]          in_first_vertex,
  input  logic [bsp_pkg::VW-1:0]          in_second_vertex,
  input  logic                            in_edge_bit,
  input  logic [bsp_pkg::CW-1:0]          vertex_count,
  output bsp_pkg::adj_req_t               adj_req,
  input  logic [bsp_pkg::MAX_VERTICES-1:0] adj_rdata,
  output bsp_pkg::node_req_t              node_req,
  input  logic [bsp_pkg::NW-1:0]          node_rdata,
  output bsp_pkg::queue_req_t             q_req,
  input  logic [bsp_pkg::VW-1:0]          q_rdata,
  output logic                            out_strobe,
  output logic signed [bsp_pkg::CW-1:0]   out_hop_distance,
  output logic [bsp_pkg::VW-1:0]          out_path_vertex,
  output logic                            out_last
);
  import bsp_pkg::*;

  localparam int N = MAX_VERTICES;

  state_t state_r, state_nxt;
  logic [VW-1:0] a_r, a_nxt, b_r, b_nxt, v_r, v_nxt, hopv_r, hopv_nxt;
  logic [VW-1:0] cur_r, cur_nxt, dist_r, dist_nxt, k_r, k_nxt;
  logic          first_r, first_nxt;
  logic [VW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [N-1:0]  fresh_r, fresh_nxt, visited_r, visited_nxt, valid_r, valid_nxt;

  logic [VW:0]   cnt;
  logic [N-1:0]  in_use, lowbit, row_a, row_b;
  logic [VW-1:0] low_idx;
  logic          accept, reach_ok;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cnt    = (vertex_count > CW'(N)) ? (VW+1)'(N) : vertex_count[VW:0];
  assign reach_ok = ({1'b0, in_first_vertex} < cnt) && ({1'b0, in_second_vertex} < cnt);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      in_use[i] = ((VW+1)'(i) < cnt);
    end
  end

  // lowest pending neighbor
  assign lowbit = fresh_r & (~fresh_r + N'(1));
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (lowbit[i]) low_idx = low_idx | VW'(i);
    end
  end

  assign row_a = valid_r[a_r] ? adj_rdata : '0;
  assign row_b = valid_r[b_r] ? adj_rdata : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_LOAD && in_edge_bit) state_nxt = S_LD_RA;
          else if (in_cmd == CMD_QUERY) state_nxt = reach_ok ? S_Q_INIT : S_UNR;
        end
      end
      S_LD_RA:   state_nxt = S_LD_WA;
      S_LD_WA:   state_nxt = S_LD_RB;
      S_LD_RB:   state_nxt = S_LD_WB;
      S_LD_WB:   state_nxt = S_IDLE;
      S_Q_INIT:  state_nxt = S_Q_POP;
      S_Q_POP: begin
        if (head_r < tail_r) state_nxt = S_Q_V;
        else state_nxt = visited_r[b_r] ? S_W_ISSUE : S_UNR;
      end
      S_Q_V:     state_nxt = S_Q_ROW;
      S_Q_ROW:   state_nxt = S_Q_SCAN;
      S_Q_SCAN:  state_nxt = (fresh_r == '0) ? S_Q_POP : S_Q_SCAN;
      S_W_ISSUE: state_nxt = S_W_DATA;
      S_W_DATA:  state_nxt = (node_rdata[NW-1:VW] == '0) ? S_E_RD : S_W_ISSUE;
      S_E_RD:    state_nxt = S_E_OUT;
      S_E_OUT:   state_nxt = (k_r == dist_r) ? S_IDLE : S_E_RD;
      S_UNR:     state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    a_nxt = a_r; b_nxt = b_r; v_nxt = v_r; hopv_nxt = hopv_r;
    cur_nxt = cur_r; dist_nxt = dist_r; k_nxt = k_r; first_nxt = first_r;
    head_nxt = head_r; tail_nxt = tail_r;
    fresh_nxt = fresh_r; visited_nxt = visited_r; valid_nxt = valid_r;
    adj_req = '0; node_req = '0; q_req = '0;
    out_strobe = 1'b0; out_hop_distance = '0; out_path_vertex = '0; out_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt = in_first_vertex;
          b_nxt = in_second_vertex;
          if (in_cmd == CMD_CLEAR) valid_nxt = '0;
        end
      end
      S_LD_RA: adj_req.raddr = a_r;
      S_LD_WA: begin
        adj_req.we = 1'b1;
        adj_req.waddr = a_r;
        adj_req.wdata = row_a | (N'(1) << b_r);
        valid_nxt[a_r] = 1'b1;
      end
      S_LD_RB: adj_req.raddr = b_r;
      S_LD_WB: begin
        adj_req.we = 1'b1;
        adj_req.waddr = b_r;
        adj_req.wdata = row_b | (N'(1) << a_r);
        valid_nxt[b_r] = 1'b1;
      end
      S_Q_INIT: begin
        visited_nxt = N'(1) << a_r;
        node_req.we = 1'b1;
        node_req.waddr = a_r;
        node_req.wdata = {VW'(0), a_r};
        q_req.we = 1'b1;
        q_req.waddr = '0;
        q_req.wdata = a_r;
        head_nxt = '0;
        tail_nxt = (VW+1)'(1);
      end
      S_Q_POP: begin
        q_req.raddr = head_r[VW-1:0];
        cur_nxt = b_r;
        first_nxt = 1'b1;
        if (head_r < tail_r) head_nxt = head_r + 1'b1;
      end
      S_Q_V: begin
        v_nxt = q_rdata;
        adj_req.raddr = q_rdata;
        node_req.raddr = q_rdata;
      end
      S_Q_ROW: begin
        fresh_nxt = (valid_r[v_r] ? adj_rdata : '0) & in_use & ~visited_r;
        hopv_nxt = node_rdata[NW-1:VW];
      end
      S_Q_SCAN: begin
        if (fresh_r != '0) begin
          fresh_nxt = fresh_r & ~lowbit;
          visited_nxt = visited_r | lowbit;
          node_req.we = 1'b1;
          node_req.waddr = low_idx;
          node_req.wdata = {hopv_r + 1'b1, v_r};
          if (!tail_r[VW]) begin
            q_req.we = 1'b1;
            q_req.waddr = tail_r[VW-1:0];
            q_req.wdata = low_idx;
            tail_nxt = tail_r + 1'b1;
          end
        end
      end
      S_W_ISSUE: node_req.raddr = cur_r;
      S_W_DATA: begin
        // a path vertex's hop count is its slot in the path buffer
        if (first_r) dist_nxt = node_rdata[NW-1:VW];
        first_nxt = 1'b0;
        q_req.we = 1'b1;
        q_req.waddr = node_rdata[NW-1:VW];
        q_req.wdata = cur_r;
        cur_nxt = node_rdata[VW-1:0];
        k_nxt = '0;
      end
      S_E_RD: q_req.raddr = k_r;
      S_E_OUT: begin
        out_strobe = 1'b1;
        out_hop_distance = signed'({1'b0, dist_r});
        out_path_vertex = q_rdata;
        out_last = (k_r == dist_r);
        k_nxt = k_r + 1'b1;
      end
      S_UNR: begin
        out_strobe = 1'b1;
        out_hop_distance = HOP_UNREACHABLE;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      visited_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      first_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      visited_r <= visited_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      first_r   <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; v_r <= v_nxt; hopv_r <= hopv_nxt;
    cur_r <= cur_nxt; dist_r <= dist_nxt; k_r <= k_nxt; fresh_r <= fresh_nxt;
  end
endmodule

### test/tb_top.sv
// self-checking testbench for the bfs shortest path unit
`timescale 1ns / 100ps

class path_scoreboard;
  logic [63:0] adj_rows [64];
  logic [6:0]  vcount;
  logic signed [6:0] exp_hop [$];
  logic [5:0]  exp_vertex [$];
  logic        exp_last [$];
  int          mismatches;

  function void clear_graph();
    foreach (adj_rows[i]) adj_rows[i] = '0;
  endfunction

  function void add_expect(logic signed [6:0] h, logic [5:0] vtx, logic lst);
    exp_hop = {exp_hop, h};
    exp_vertex = {exp_vertex, vtx};
    exp_last = {exp_last, lst};
  endfunction

  // predict the results of one accepted request
  function void note_request(logic [1:0] cmd, logic [5:0] a, logic [5:0] b, logic bit_in);
    int cnt, qh, qt, v, len, cur;
    logic [63:0] seen, in_use, fresh;
    int hop [64];
    int par [64];
    int q [64];
    if (cmd == bsp_pkg::CMD_CLEAR) begin
      clear_graph();
      return;
    end
    if (cmd == bsp_pkg::CMD_LOAD) begin
      if (bit_in) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
      return;
    end
    if (cmd != bsp_pkg::CMD_QUERY) return;
    cnt = (vcount > 64) ? 64 : vcount;
    seen = '0;
    if (a < cnt) begin
      in_use = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 1);
      seen[a] = 1'b1;
      hop[a] = 0;
      par[a] = a;
      q[0] = a;
      qh = 0;
      qt = 1;
      while (qh < qt) begin
        v = q[qh];
        qh++;
        fresh = adj_rows[v] & in_use & ~seen;
        for (int u = 0; u < cnt; u++) begin
          if (fresh[u]) begin
            seen[u] = 1'b1;
            hop[u] = (hop[v] + 1) & 63;
            par[u] = v;
            if (qt < 64) begin
              q[qt] = u;
              qt++;
            end
          end
        end
      end
    end
    if (a >= cnt || b >= cnt || !seen[b]) begin
      add_expect(bsp_pkg::HOP_UNREACHABLE, '0, 1'b1);
      return;
    end
    len = hop[b] + 1;
    begin
      int path [64];
      cur = b;
      for (int k = len - 1; k >= 0; k--) begin
        path[k] = cur;
        cur = par[cur];
      end
      for (int k = 0; k < len; k++) begin
        add_expect(7'(len - 1), 6'(path[k]), k == len - 1);
      end
    end
  endfunction

  function void check_result(logic signed [6:0] hop, logic [5:0] vtx, logic lst);
    if (exp_hop.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result hop=%0d vertex=%0d", hop, vtx);
      return;
    end
    if (hop !== exp_hop[0] || vtx !== exp_vertex[0] || lst !== exp_last[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp hop=%0d vertex=%0d last=%0b, got hop=%0d vertex=%0d last=%0b",
                 exp_hop[0], exp_vertex[0], exp_last[0], hop, vtx, lst);
    end
    void'(exp_hop.pop_front());
    void'(exp_vertex.pop_front());
    void'(exp_last.pop_front());
  endfunction
endclass

module tb_top;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = '0;
  logic [5:0] in_first_vertex = '0;
  logic [5:0] in_second_vertex = '0;
  logic in_edge_bit = 1'b0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic out_strobe;
  logic signed [6:0] out_hop_distance;
  logic [5:0] out_path_vertex;
  logic out_last;

  path_scoreboard board;
  int idle_pct;
  int quiet_cycles;

  bfs_shortest_path_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_first_vertex(in_first_vertex),
    .in_second_vertex(in_second_vertex), .in_edge_bit(in_edge_bit),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_hop_distance(out_hop_distance),
    .out_path_vertex(out_path_vertex), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_result(out_hop_distance, out_path_vertex, out_last);
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // start stays high across back-to-back requests and drops only while idling
  task automatic send_request(logic [1:0] cmd, logic [5:0] a, logic [5:0] b, logic e);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_first_vertex <= a;
    in_second_vertex <= b;
    in_edge_bit <= e;
    do @(posedge clk); while (busy);
    board.note_request(cmd, a, b, e);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.exp_hop.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.vcount = value;
  endtask

  // random chains give long paths; random edges add branching
  task automatic random_phase(int n);
    int kind;
    logic [5:0] a;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      a = 6'($urandom);
      if (kind < 45) send_request(bsp_pkg::CMD_LOAD, a, 6'($urandom_range(63)), 1'b1);
      else if (kind < 55)
        send_request(bsp_pkg::CMD_LOAD, a, a + 6'd1, 1'($urandom));
      else if (kind < 92)
        send_request(bsp_pkg::CMD_QUERY, 6'($urandom), 6'($urandom), 1'($urandom));
      else if (kind < 96) send_request(bsp_pkg::CMD_CLEAR, a, 6'($urandom), 1'($urandom));
      else send_request(2'd3, a, 6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.clear_graph();
    board.vcount = 64;
    board.mismatches = 0;
    quiet_cycles = 0;
    idle_pct = 16;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: chain 0..5, self edge, high vertices, no-op load
    for (int v = 0; v < 5; v++) send_request(bsp_pkg::CMD_LOAD, 6'(v), 6'(v + 1), 1'b1);
    send_request(bsp_pkg::CMD_LOAD, 6'd3, 6'd3, 1'b1);
    send_request(bsp_pkg::CMD_LOAD, 6'd5, 6'd63, 1'b1);
    send_request(bsp_pkg::CMD_LOAD, 6'd0, 6'd62, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd63, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd63, 6'd2, 1'b1);
    send_request(bsp_pkg::CMD_QUERY, 6'd4, 6'd4, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd62, 1'b0);
    send_request(2'd3, 6'd0, 6'd1, 1'b1);
    write_count(7'd6);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd5, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd63, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd6, 6'd0, 1'b0);
    write_count(7'd1);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd0, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd1, 1'b0);
    write_count(7'd0);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd0, 1'b0);
    write_count(7'd127);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd63, 1'b0);
    send_request(bsp_pkg::CMD_CLEAR, 6'd0, 6'd0, 1'b0);
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd5, 1'b0);
    // full 64-vertex chain for the longest path
    for (int v = 0; v < 63; v++) send_request(bsp_pkg::CMD_LOAD, 6'(v), 6'(v + 1), 1'b1);
    idle_pct = 0;
    send_request(bsp_pkg::CMD_QUERY, 6'd0, 6'd63, 1'b0);
    idle_pct = 16;

    write_count(7'd64);
    random_phase(60);
    write_count(7'd20);
    random_phase(50);
    idle_pct = 74;
    write_count(7'd40);
    random_phase(50);
    write_count(7'd2);
    random_phase(20);
    idle_pct = 0;
    write_count(7'd64);
    random_phase(44);
    drain();

    if (board.mismatches == 0 && board.exp_hop.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
